@@ hw/rtl/lbe_pkg.sv @@
// ----------------------------------------------------------------------------
// lbe_pkg: shared types and constants of the band effort block
// Field widths, mode and register codes, and the metadata that rides along
// with an item through the two pipelined dividers.
// ----------------------------------------------------------------------------
package lbe_pkg;

  localparam int VAL_W     = 32;
  localparam int IDX_W     = 6;
  localparam int EFF_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] MODE_EVAL     = 2'd0;
  localparam logic [1:0] MODE_LOAD_LO  = 2'd1;
  localparam logic [1:0] MODE_LOAD_HI  = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HIGH = 1'b1;

  localparam logic [EFF_W-1:0] EFFORT_ONE  = 17'h10000;
  localparam logic [EFF_W-1:0] EFFORT_ZERO = 17'h00000;

  // Item metadata carried through the grid divider.
  typedef struct packed {
    logic [1:0]              mode;
    logic                    below;
    logic                    above;
    logic                    zero_span;
    logic signed [VAL_W-1:0] velocity;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
  } grid_meta_t;

  // Item metadata carried through the effort divider.
  typedef struct packed {
    logic signed [VAL_W-1:0] lower;
    logic signed [VAL_W-1:0] upper;
    logic                    special;
    logic                    special_one;
  } band_meta_t;

endpackage

@@ hw/rtl/lbe_ram.sv @@
// ----------------------------------------------------------------------------
// lbe_ram: generic dual read port RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module lbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/lbe_div_pipe.sv @@
// ----------------------------------------------------------------------------
// lbe_div_pipe: pipelined restoring divider
// One quotient bit per stage; the partial remainder must start below the
// divisor. Low dividend bits are shifted in one per stage.
// ----------------------------------------------------------------------------
module lbe_div_pipe #(
  parameter int DW = 33,
  parameter int QW = 16,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_div,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  logic          vld_r [QW];
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] div_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [PW-1:0] pay_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_i;
    logic [DW-1:0] r_i;
    logic [QW-1:0] l_i;
    logic [DW-1:0] d_i;
    logic [QW-1:0] q_i;
    logic [PW-1:0] p_i;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign v_i = in_vld;
      assign r_i = in_rem;
      assign l_i = in_low;
      assign d_i = in_div;
      assign q_i = '0;
      assign p_i = in_pay;
    end else begin : g_next
      assign v_i = vld_r[k-1];
      assign r_i = rem_r[k-1];
      assign l_i = low_r[k-1];
      assign d_i = div_r[k-1];
      assign q_i = quo_r[k-1];
      assign p_i = pay_r[k-1];
    end

    always_comb begin
      trial   = {r_i, l_i[QW-1]};
      diff    = trial - {1'b0, d_i};
      ge      = (trial >= {1'b0, d_i});
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= {l_i[QW-2:0], 1'b0};
        div_r[k] <= d_i;
        quo_r[k] <= {q_i[QW-2:0], ge};
        pay_r[k] <= p_i;
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_quo = quo_r[QW-1];
  assign out_pay = pay_r[QW-1];

endmodule

@@ hw/rtl/lut_band_effort.sv @@
// ----------------------------------------------------------------------------
// lut_band_effort: velocity band effort from altitude indexed bound tables
// Evaluates a normalized position of velocity between two interpolated
// bounds, and loads the bound tables.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while not stalled and gives one result
// beat for each evaluate beat, none for a load or reserved beat. Evaluate
// beats pass stages 0 and 1, the grid divider, stages 2 to 5, the effort
// divider and the output register; the two pipelined dividers, one stage
// per quotient bit, map altitude onto the grid and scale the band. Load
// beats write the tables at the same stage at which evaluates read them,
// so a load is seen by every evaluate that follows it. The whole pipeline
// stalls as one when a result waits at the output and out_stall is high.
// The tables hold no defined value after reset: every entry an evaluate
// touches must be loaded first. Grid limits must be written through the cfg
// port only while no beat is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module lut_band_effort #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbe_pkg::VAL_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic signed [lbe_pkg::VAL_W-1:0] in_altitude,
  input  logic signed [lbe_pkg::VAL_W-1:0] in_velocity,
  input  logic [lbe_pkg::IDX_W-1:0]       in_entry_index,
  input  logic signed [lbe_pkg::VAL_W-1:0] in_entry_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lbe_pkg::EFF_W-1:0]       out_effort,
  output logic signed [lbe_pkg::VAL_W-1:0] out_lower_bound,
  output logic signed [lbe_pkg::VAL_W-1:0] out_upper_bound
);

  import lbe_pkg::*;

  localparam int AW      = $clog2(TABLE_ENTRIES);
  localparam int LW      = AW;
  localparam int OW      = VAL_W + 1;           // offset, span, band widths
  localparam int NW      = OW + LW;             // scaled offset
  localparam int QW      = FRAC_W + LW;         // grid position bits
  // One bit above the wider of the table address and the load index, so
  // that the table depth itself is representable.
  localparam int CW      = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [AW-1:0] LAST_W = AW'(TABLE_ENTRIES - 2);
  localparam logic [LW-1:0] LAST_E = LW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_ENTRIES);

  // Configuration registers.
  logic signed [VAL_W-1:0] grid_low_r;
  logic signed [VAL_W-1:0] grid_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_low_r  <= '0;
      grid_high_r <= 32'sd65536000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_LOW:  grid_low_r  <= cfg_data;
        CFG_GRID_HIGH: grid_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: everything moves unless a finished result is held.
  logic adv;
  logic out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 0: compare against the limits and form the offset.
  logic signed [OW-1:0] span_c;
  logic signed [OW-1:0] off_c;
  grid_meta_t           meta_c;

  always_comb begin
    span_c           = {grid_high_r[VAL_W-1], grid_high_r} -
                       {grid_low_r[VAL_W-1], grid_low_r};
    off_c            = {in_altitude[VAL_W-1], in_altitude} -
                       {grid_low_r[VAL_W-1], grid_low_r};
    meta_c.mode      = in_mode;
    meta_c.below     = (in_altitude < grid_low_r);
    meta_c.above     = (in_altitude > grid_high_r);
    meta_c.zero_span = (span_c == '0);
    meta_c.velocity  = in_velocity;
    meta_c.entry_index = in_entry_index;
    meta_c.entry_value = in_entry_value;
  end

  logic                s0_vld_r;
  grid_meta_t          s0_meta_r;
  logic [OW-1:0]       s0_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      // Beats with the reserved mode are dropped here.
      s0_vld_r <= in_valid && (in_mode != MODE_RESERVED);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_meta_r <= meta_c;
      s0_off_r  <= off_c;
    end
  end

  // Stage 1: scale the offset by the number of grid intervals.
  logic                s1_vld_r;
  grid_meta_t          s1_meta_r;
  logic [NW-1:0]       s1_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r <= s0_meta_r;
      s1_num_r  <= NW'(s0_off_r) * NW'(TABLE_ENTRIES - 1);
    end
  end

  // Grid divider: position = scaled offset * 65536 / span. The position is
  // below TABLE_ENTRIES * 65536, so QW quotient bits suffice.
  logic               gd_vld;
  logic [QW-1:0]      gd_quo;
  logic [$bits(grid_meta_t)-1:0] gd_pay;
  grid_meta_t         gd_meta;

  lbe_div_pipe #(
    .DW (OW),
    .QW (QW),
    .PW ($bits(grid_meta_t))
  ) u_grid_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s1_vld_r),
    .in_rem  (s1_num_r[NW-1:LW]),
    .in_low  ({s1_num_r[LW-1:0], {FRAC_W{1'b0}}}),
    .in_div  (span_c),
    .in_pay  (s1_meta_r),
    .out_vld (gd_vld),
    .out_quo (gd_quo),
    .out_pay (gd_pay)
  );

  assign gd_meta = grid_meta_t'(gd_pay);

  // Stage 2: entry and fraction, table read, and table writes for loads.
  logic [LW-1:0]       whole_c;
  logic [AW-1:0]       idx_c;
  logic [FRAC_W:0]     frac_c;
  logic [CW-1:0]       load_idx_c;
  logic                load_ok_c;
  logic                we_lo_c;
  logic                we_hi_c;

  always_comb begin
    whole_c = gd_quo[QW-1:FRAC_W];
    if (gd_meta.below) begin
      idx_c  = '0;
      frac_c = '0;
    end else if (gd_meta.above) begin
      idx_c  = LAST_W;
      frac_c = {1'b1, {FRAC_W{1'b0}}};
    end else if (gd_meta.zero_span) begin
      idx_c  = '0;
      frac_c = '0;
    end else if (whole_c >= LAST_E) begin
      idx_c  = LAST_W;
      frac_c = {1'b1, {FRAC_W{1'b0}}};
    end else begin
      idx_c  = whole_c;
      frac_c = {1'b0, gd_quo[FRAC_W-1:0]};
    end
    load_idx_c = CW'(gd_meta.entry_index);
    load_ok_c  = (load_idx_c < DEPTH_C);
    we_lo_c    = adv && gd_vld && load_ok_c && (gd_meta.mode == MODE_LOAD_LO);
    we_hi_c    = adv && gd_vld && load_ok_c && (gd_meta.mode == MODE_LOAD_HI);
  end

  logic [VAL_W-1:0] lo_a;
  logic [VAL_W-1:0] lo_b;
  logic [VAL_W-1:0] up_a;
  logic [VAL_W-1:0] up_b;

  lbe_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_lower_ram (
    .clk     (clk),
    .we      (we_lo_c),
    .waddr   (load_idx_c[AW-1:0]),
    .wdata   (gd_meta.entry_value),
    .re      (adv),
    .raddr_a (idx_c),
    .raddr_b (idx_c + AW'(1)),
    .rdata_a (lo_a),
    .rdata_b (lo_b)
  );

  lbe_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_upper_ram (
    .clk     (clk),
    .we      (we_hi_c),
    .waddr   (load_idx_c[AW-1:0]),
    .wdata   (gd_meta.entry_value),
    .re      (adv),
    .raddr_a (idx_c),
    .raddr_b (idx_c + AW'(1)),
    .rdata_a (up_a),
    .rdata_b (up_b)
  );

  logic                    s2_vld_r;
  logic [FRAC_W:0]         s2_frac_r;
  logic signed [VAL_W-1:0] s2_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= gd_vld && (gd_meta.mode == MODE_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_frac_r <= frac_c;
      s2_vel_r  <= gd_meta.velocity;
    end
  end

  // Stage 3: the four blend products, one multiplier per lane.
  localparam int MW = VAL_W + FRAC_W + 2;
  logic [FRAC_W:0]         rfrac_c;
  logic signed [FRAC_W+1:0] wa_c;
  logic signed [FRAC_W+1:0] wb_c;

  assign rfrac_c = {1'b1, {FRAC_W{1'b0}}} - s2_frac_r;
  assign wa_c    = {1'b0, rfrac_c};
  assign wb_c    = {1'b0, s2_frac_r};

  logic                    s3_vld_r;
  logic signed [MW-1:0]    s3_lo_pa_r;
  logic signed [MW-1:0]    s3_lo_pb_r;
  logic signed [MW-1:0]    s3_up_pa_r;
  logic signed [MW-1:0]    s3_up_pb_r;
  logic signed [VAL_W-1:0] s3_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_lo_pa_r <= $signed(lo_a) * wa_c;
      s3_lo_pb_r <= $signed(lo_b) * wb_c;
      s3_up_pa_r <= $signed(up_a) * wa_c;
      s3_up_pb_r <= $signed(up_b) * wb_c;
      s3_vel_r   <= s2_vel_r;
    end
  end

  // Stage 4: sum, round half up, and floor shift to Q16.16.
  localparam logic signed [MW-1:0] HALF = MW'(32768);
  logic signed [MW-1:0] lo_sum_c;
  logic signed [MW-1:0] up_sum_c;

  assign lo_sum_c = s3_lo_pa_r + s3_lo_pb_r + HALF;
  assign up_sum_c = s3_up_pa_r + s3_up_pb_r + HALF;

  logic                    s4_vld_r;
  logic signed [VAL_W-1:0] s4_lo_r;
  logic signed [VAL_W-1:0] s4_up_r;
  logic signed [VAL_W-1:0] s4_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_lo_r  <= lo_sum_c[FRAC_W+VAL_W-1:FRAC_W];
      s4_up_r  <= up_sum_c[FRAC_W+VAL_W-1:FRAC_W];
      s4_vel_r <= s3_vel_r;
    end
  end

  // Stage 5: band position and the cases that need no division.
  logic signed [OW-1:0] num_c;
  logic signed [OW-1:0] den_c;
  logic [OW-1:0]        an_c;
  logic [OW-1:0]        ad_c;
  band_meta_t           bm_c;

  always_comb begin
    num_c = {s4_vel_r[VAL_W-1], s4_vel_r} - {s4_lo_r[VAL_W-1], s4_lo_r};
    den_c = {s4_up_r[VAL_W-1], s4_up_r} - {s4_lo_r[VAL_W-1], s4_lo_r};
    an_c  = num_c[OW-1] ? OW'(-num_c) : OW'(num_c);
    ad_c  = den_c[OW-1] ? OW'(-den_c) : OW'(den_c);
    bm_c.lower = s4_lo_r;
    bm_c.upper = s4_up_r;
    if (den_c == '0) begin
      // A zero-width band is a step at the lower bound.
      bm_c.special     = 1'b1;
      bm_c.special_one = (num_c > 0);
    end else if ((num_c == '0) || (num_c[OW-1] != den_c[OW-1])) begin
      bm_c.special     = 1'b1;
      bm_c.special_one = 1'b0;
    end else if (an_c >= ad_c) begin
      bm_c.special     = 1'b1;
      bm_c.special_one = 1'b1;
    end else begin
      bm_c.special     = 1'b0;
      bm_c.special_one = 1'b0;
    end
  end

  logic          s5_vld_r;
  logic [OW-1:0] s5_an_r;
  logic [OW-1:0] s5_ad_r;
  band_meta_t    s5_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_an_r   <= bm_c.special ? '0 : an_c;
      s5_ad_r   <= bm_c.special ? OW'(1) : ad_c;
      s5_meta_r <= bm_c;
    end
  end

  // Effort divider: |num| * 65536 / |den| with |num| below |den|.
  logic                           ed_vld;
  logic [FRAC_W-1:0]              ed_quo;
  logic [$bits(band_meta_t)-1:0]  ed_pay;
  band_meta_t                     ed_meta;

  lbe_div_pipe #(
    .DW (OW),
    .QW (FRAC_W),
    .PW ($bits(band_meta_t))
  ) u_effort_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s5_vld_r),
    .in_rem  (s5_an_r),
    .in_low  ('0),
    .in_div  (s5_ad_r),
    .in_pay  (s5_meta_r),
    .out_vld (ed_vld),
    .out_quo (ed_quo),
    .out_pay (ed_pay)
  );

  assign ed_meta = band_meta_t'(ed_pay);

  // Output register.
  logic [EFF_W-1:0]        out_effort_r;
  logic signed [VAL_W-1:0] out_lower_r;
  logic signed [VAL_W-1:0] out_upper_r;
  logic [EFF_W-1:0]        effort_nxt;

  always_comb begin
    if (ed_meta.special) begin
      effort_nxt = ed_meta.special_one ? EFFORT_ONE : EFFORT_ZERO;
    end else begin
      effort_nxt = {1'b0, ed_quo};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ed_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_effort_r <= effort_nxt;
      out_lower_r  <= ed_meta.lower;
      out_upper_r  <= ed_meta.upper;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_effort      = out_effort_r;
  assign out_lower_bound = out_lower_r;
  assign out_upper_bound = out_upper_r;

endmodule

@@ tb/lut_band_effort_test.sv @@
// ----------------------------------------------------------------------------
// lut_band_effort_test: self-checking bench for the band effort block
// Loads both bound tables, evaluates directed and random altitude/velocity
// beats under several grid settings and random idling on both sides, and
// compares every result beat against an in-bench predictor.
// ----------------------------------------------------------------------------
module lut_band_effort_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lbe_pkg::*;

  localparam int ENTRIES = 64;
  // Allow a wide margin over the pipeline depth for the drain at the end.
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = MODE_EVAL;
  logic signed [VAL_W-1:0] in_altitude = '0;
  logic signed [VAL_W-1:0] in_velocity = '0;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic signed [VAL_W-1:0] in_entry_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [EFF_W-1:0] out_effort;
  logic signed [VAL_W-1:0] out_lower_bound;
  logic signed [VAL_W-1:0] out_upper_bound;

  always #5 clk = ~clk;

  lut_band_effort #(.TABLE_ENTRIES(ENTRIES)) u_dut (.*);

  typedef struct packed {
    logic [EFF_W-1:0] effort;
    logic signed [VAL_W-1:0] lower;
    logic signed [VAL_W-1:0] upper;
  } band_result_t;

  // Predictor state: a private copy of the tables and the grid limits.
  logic signed [VAL_W-1:0] lower_copy [ENTRIES];
  logic signed [VAL_W-1:0] upper_copy [ENTRIES];
  logic signed [VAL_W-1:0] grid_lo = 0;
  logic signed [VAL_W-1:0] grid_hi = 65536000;

  band_result_t pending_bands[$];
  int errors = 0;
  int sender_idle = 0;  // percent of cycles the sender holds back
  int receiver_idle = 0;
  bit hold_off = 1'b0;

  function automatic logic signed [VAL_W-1:0] blend_bound(
      longint a, longint b, longint f);
    longint s;
    longint q;
    s = a * (65536 - f) + b * f + 32768;
    q = s / 65536;
    if ((s % 65536) != 0 && s < 0) q = q - 1;
    return q[VAL_W-1:0];
  endfunction

  function automatic logic [EFF_W-1:0] band_position(longint v, longint lo, longint up);
    longint num;
    longint den;
    num = v - lo;
    den = up - lo;
    if (den == 0) return (num > 0) ? EFFORT_ONE : EFFORT_ZERO;
    if (num == 0 || ((num < 0) != (den < 0))) return EFFORT_ZERO;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    if (num >= den) return EFFORT_ONE;
    return EFF_W'((num * 65536) / den);
  endfunction

  function automatic band_result_t predict_band(logic signed [VAL_W-1:0] alt,
                                                logic signed [VAL_W-1:0] vel);
    band_result_t r;
    longint span;
    longint unsigned pos;
    int w;
    longint f;
    if (alt < grid_lo) begin
      w = 0; f = 0;
    end else if (alt > grid_hi) begin
      w = ENTRIES - 2; f = 65536;
    end else begin
      span = longint'(grid_hi) - longint'(grid_lo);
      if (span == 0) begin
        w = 0; f = 0;
      end else begin
        // 63 * 2^32 * 2^16 fits in 64 bits unsigned.
        pos = (longint'(ENTRIES - 1) * (longint'(alt) - longint'(grid_lo)) * 65536) /
              span;
        if ((pos >> 16) >= ENTRIES - 1) begin
          w = ENTRIES - 2; f = 65536;
        end else begin
          w = int'(pos >> 16); f = longint'(pos & 64'hFFFF);
        end
      end
    end
    r.lower = blend_bound(lower_copy[w], lower_copy[w+1], f);
    r.upper = blend_bound(upper_copy[w], upper_copy[w+1], f);
    r.effort = band_position(vel, r.lower, r.upper);
    return r;
  endfunction

  task automatic write_grid(logic [CFG_IDX_W-1:0] idx, logic signed [VAL_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_LOW) grid_lo = val;
    else grid_hi = val;
  endtask

  // Offers one beat and returns once it is accepted. Random gaps go first,
  // so valid never drops between two back-to-back beats.
  task automatic send_beat(logic [1:0] mode, logic signed [VAL_W-1:0] alt,
                           logic signed [VAL_W-1:0] vel, logic [IDX_W-1:0] idx,
                           logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_altitude <= alt;
    in_velocity <= vel;
    in_entry_index <= idx;
    in_entry_value <= val;
    do @(posedge clk); while (in_stall);
    // Accepted at this edge: update the predictor in beat order.
    if (mode == MODE_LOAD_LO) lower_copy[idx] = val;
    else if (mode == MODE_LOAD_HI) upper_copy[idx] = val;
    else if (mode == MODE_EVAL) pending_bands.push_back(predict_band(alt, vel));
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(200000)) - 100000;
      default: return $signed($urandom());
    endcase
  endfunction

  // Altitude mostly inside the grid, sometimes at or past its limits.
  function automatic logic signed [VAL_W-1:0] rand_alt();
    longint span;
    span = longint'(grid_hi) - longint'(grid_lo);
    case ($urandom_range(9))
      0: return grid_lo;
      1: return grid_hi;
      2: return rand_val();
      default: begin
        if (span <= 0) return grid_lo;
        return VAL_W'(longint'(grid_lo) + (longint'({$urandom(), $urandom()}) & 64'h7FFFFFFFFFFFFFFF) % (span + 1));
      end
    endcase
  endfunction

  task automatic load_tables_random();
    for (int i = 0; i < ENTRIES; i++) begin
      send_beat(MODE_LOAD_LO, '0, '0, IDX_W'(i), rand_val());
      send_beat(MODE_LOAD_HI, '0, '0, IDX_W'(i), rand_val());
    end
  endtask

  task automatic random_phase(int beats);
    for (int n = 0; n < beats; n++) begin
      case ($urandom_range(19))
        0: send_beat(MODE_LOAD_LO, rand_val(), rand_val(), IDX_W'($urandom()), rand_val());
        1: send_beat(MODE_LOAD_HI, rand_val(), rand_val(), IDX_W'($urandom()), rand_val());
        2: send_beat(MODE_RESERVED, rand_val(), rand_val(), IDX_W'($urandom()), rand_val());
        default: send_beat(MODE_EVAL, rand_alt(), rand_val(), IDX_W'($urandom()), rand_val());
      endcase
    end
  endtask

  // Receiver: random stall, plus a long hold-off that fills the pipeline.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < receiver_idle);
  end

  initial begin
    int count;
    wait (rst_n);
    #1;
    forever begin
      wait (hold_off);
      count = 0;
      while (count < 200) begin
        @(posedge clk);
        count++;
      end
      hold_off = 1'b0;
    end
  end

  // Result checker: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    band_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bands.size() == 0) begin
        $display("%0t: unexpected result effort=%0d lower=%0d upper=%0d", $time,
                 out_effort, out_lower_bound, out_upper_bound);
        errors++;
      end else begin
        want = pending_bands.pop_front();
        if (out_effort !== want.effort) begin
          $display("%0t: effort expected %0d actual %0d", $time, want.effort, out_effort);
          errors++;
        end
        if (out_lower_bound !== want.lower) begin
          $display("%0t: lower_bound expected %0d actual %0d", $time, want.lower,
                   out_lower_bound);
          errors++;
        end
        if (out_upper_bound !== want.upper) begin
          $display("%0t: upper_bound expected %0d actual %0d", $time, want.upper,
                   out_upper_bound);
          errors++;
        end
      end
    end
  end

  // Directed stimulus table. A typed-in effort of -1 means the predictor
  // supplies the expectation; otherwise the row is checked against it too.
  typedef struct {
    logic [1:0] mode;
    logic signed [VAL_W-1:0] alt;
    logic signed [VAL_W-1:0] vel;
    logic [IDX_W-1:0] idx;
    logic signed [VAL_W-1:0] val;
    int effort_known;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{MODE_EVAL, 32'sh80000000, 32'sd0, 6'd0, 32'sd0, 0},       // below grid: band 0..0
    '{MODE_EVAL, 32'sh7FFFFFFF, 32'sd1, 6'd0, 32'sd0, 65536},   // above grid: zero band
    '{MODE_EVAL, 32'sd0, 32'sh80000000, 6'd0, 32'sd0, 0},
    '{MODE_EVAL, 32'sd65536000, 32'sh7FFFFFFF, 6'd0, 32'sd0, 65536},
    '{MODE_LOAD_LO, 32'sd0, 32'sd0, 6'd0, 32'sh80000000, -1},
    '{MODE_LOAD_HI, 32'sd0, 32'sd0, 6'd0, 32'sh7FFFFFFF, -1},
    '{MODE_LOAD_LO, 32'sd0, 32'sd0, 6'd1, 32'sd0, -1},
    '{MODE_LOAD_HI, 32'sd0, 32'sd0, 6'd1, 32'sd65536, -1},
    '{MODE_LOAD_LO, 32'sd0, 32'sd0, 6'd63, 32'sd100, -1},
    '{MODE_LOAD_HI, 32'sd0, 32'sd0, 6'd63, 32'sd50, -1},        // inverted band at top
    '{MODE_RESERVED, 32'sd0, 32'sd0, 6'd0, 32'sd12345, -1},     // unused mode
    '{MODE_EVAL, 32'sh80000000, 32'sh80000000, 6'd0, 32'sd0, 0},
    '{MODE_EVAL, 32'sh80000000, 32'sh7FFFFFFF, 6'd0, 32'sd0, 65536},
    '{MODE_EVAL, 32'sh80000000, 32'sd0, 6'd0, 32'sd0, -1},
    '{MODE_EVAL, 32'sd500000, 32'sd30000, 6'd0, 32'sd0, -1},    // between entries 0 and 1
    '{MODE_EVAL, 32'sh7FFFFFFF, 32'sd75, 6'd0, 32'sd0, -1},     // inverted band
    '{MODE_EVAL, 32'sd65536000, 32'sd40, 6'd0, 32'sd0, 65536}   // below both bounds
  };

  initial begin
    band_result_t want;
    // The directed rows touch only entries 0, 1, 62 and 63, so those are
    // loaded with zero first in both tables.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      send_beat(MODE_LOAD_LO, '0, '0, IDX_W'((k < 2) ? k : ENTRIES - 4 + k), '0);
      send_beat(MODE_LOAD_HI, '0, '0, IDX_W'((k < 2) ? k : ENTRIES - 4 + k), '0);
    end
    foreach (directed[i]) begin
      send_beat(directed[i].mode, directed[i].alt, directed[i].vel, directed[i].idx,
                directed[i].val);
      if (directed[i].effort_known >= 0 && directed[i].mode == MODE_EVAL) begin
        want = pending_bands[$];
        if (want.effort != EFF_W'(directed[i].effort_known)) begin
          $display("%0t: directed row %0d effort expected %0d predicted %0d", $time, i,
                   directed[i].effort_known, want.effort);
          errors++;
        end
      end
    end
    go_quiet();

    // Phase 1: default grid, sender idles little, receiver a lot.
    sender_idle = 17; receiver_idle = 46;
    load_tables_random();
    random_phase(100);
    go_quiet();

    // Phase 2: full-range grid, roles swapped, with a long hold-off.
    write_grid(CFG_GRID_LOW, 32'sh80000000);
    write_grid(CFG_GRID_HIGH, 32'sh7FFFFFFF);
    sender_idle = 46; receiver_idle = 17;
    hold_off = 1'b1;
    random_phase(60);
    go_quiet();

    // Phase 3: zero span, then a narrow grid with a long hold-off, no random idling.
    sender_idle = 0; receiver_idle = 0;
    write_grid(CFG_GRID_LOW, 32'sd4096);
    write_grid(CFG_GRID_HIGH, 32'sd4096);
    random_phase(20);
    go_quiet();
    write_grid(CFG_GRID_LOW, -32'sd1000);
    write_grid(CFG_GRID_HIGH, 32'sd63);
    hold_off = 1'b1;
    random_phase(80);
    go_quiet();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
